// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: implication failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/nns_pkg.sv =====
// Types, constants and helpers for the nearest-neighbor scaler.
`default_nettype none
package nns_pkg;

  localparam int QW       = 10;
  localparam int NW       = 20;
  localparam int DIV_BITS = 2;
  localparam int DIV_STG  = QW / DIV_BITS;
  localparam int SIDX_W   = 20;
  localparam int CMP_W    = 25;
  localparam int FB_ROWS  = 480;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_LEFT   = 3'd2,
    REG_DST_TOP    = 3'd3,
    REG_DST_WIDTH  = 3'd4,
    REG_DST_HEIGHT = 3'd5
  } reg_index_t;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef struct packed {
    logic        op;
    logic [18:0] src_index;
    logic [7:0]  byte_lo;
    logic [7:0]  byte_mid;
    logic [7:0]  byte_hi;
    logic [9:0]  dst_col;
    logic [8:0]  dst_row;
  } in_item_t;

  typedef struct packed {
    logic [18:0] fb_address;
    logic [23:0] colour;
    logic        out_of_range;
  } out_item_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [QW:0] div_step(input logic [QW-1:0] r, input logic b,
                                           input logic [QW-1:0] d);
    logic [QW:0] t;
    logic [QW:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, s[QW-1:0]};
    end
    return {1'b0, t[QW-1:0]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nns_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module nns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 384000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nns_div.sv =====
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
`default_nettype none
module nns_div (
  input  wire logic                        clk,
  input  wire logic [nns_pkg::DIV_STG-1:0] adv,
  input  wire logic [nns_pkg::NW-1:0]      dividend,
  input  wire logic [nns_pkg::QW-1:0]      divisor,
  output logic      [nns_pkg::QW-1:0]      quotient
);
  import nns_pkg::*;

  logic [QW-1:0] rem_q [DIV_STG];
  logic [QW-1:0] low_q [DIV_STG];
  logic [QW-1:0] quo_q [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    logic [QW-1:0] r_in, l_in, q_in;
    logic [QW-1:0] r, l, q;
    logic [QW:0]   t;

    if (k == 0) begin : g_first
      assign r_in = dividend[NW-1:NW-QW];
      assign l_in = dividend[QW-1:0];
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign l_in = low_q[k-1];
      assign q_in = quo_q[k-1];
    end

    always_comb begin
      r = r_in;
      l = l_in;
      q = q_in;
      t = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        t = div_step(r, l[QW-1], divisor);
        r = t[QW-1:0];
        q = {q[QW-2:0], t[QW]};
        l = {l[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_q[k] <= r;
        low_q[k] <= l;
        quo_q[k] <= q;
      end
    end
  end

  assign quotient = quo_q[DIV_STG-1];

endmodule
`default_nettype wire

// ===== hdl/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor image scaler: source store, scaling pipeline and output stage.
// Usage:
//   Input channel in_valid/in_stall/in_item carries loads (op 0) and renders
//   (op 1). A load writes one 24-bit pixel into the source store and gives no
//   result. A render maps a destination pixel to its nearest source pixel and
//   returns the framebuffer word address, the colour and an out_of_range flag.
//   Output channel out_valid/out_stall/out_item carries one result per render.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Timing:
//   Eight register stages: input, five divider stages (two quotient bits
//   each), source index, store read. A render result is presented from the
//   store read stage. One item per cycle is accepted sustained while the
//   receiver does not stall; the store takes one write or one read per cycle.
// Reset clears all valid bits and restores the register defaults; the store
// is not cleared and holds garbage until loaded.
// When the receiver stalls, the output stage holds its result and bubbles
// upstream collapse; in_stall rises only once every stage is occupied.
`default_nettype none
module nearest_neighbor_image_scaler #(
  parameter int MAX_SRC_WIDTH  = 800,
  parameter int MAX_SRC_HEIGHT = 480,
  parameter int FB_STRIDE      = 800
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire nns_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output nns_pkg::out_item_t      out_item,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [9:0]         cfg_data
);
  import nns_pkg::*;

  `include "assert_macros.svh"

  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int NSTG        = DIV_STG + 3;
  localparam int LAST        = NSTG - 1;
  localparam int IDX_STG     = DIV_STG + 1;

  typedef struct packed {
    logic              op;
    logic              oor;
    logic [18:0]       fb_address;
    logic              load_ok;
    logic [ADDR_W-1:0] idx;
    logic [23:0]       pix;
  } side_t;

  // configuration
  logic [9:0] src_width, dst_left, dst_width;
  logic [8:0] src_height, dst_top, dst_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 10'd800;
      src_height <= 9'd480;
      dst_left   <= '0;
      dst_top    <= '0;
      dst_width  <= 10'd800;
      dst_height <= 9'd480;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        REG_DST_LEFT:   dst_left   <= cfg_data;
        REG_DST_TOP:    dst_top    <= cfg_data[8:0];
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] valid;
  logic [NSTG:0]   ready;
  logic [NSTG-1:0] move;

  assign ready[NSTG] = !out_stall;
  for (genvar k = 0; k < NSTG; k++) begin : g_ctl
    assign ready[k] = !valid[k] || ready[k+1];
    if (k == 0) begin : g_m0
      assign move[k] = in_valid && ready[k];
    end else begin : g_mk
      assign move[k] = valid[k-1] && ready[k];
    end
  end

  logic s6_render;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (ready[k]) begin
          if (k == 0) begin
            valid[k] <= in_valid;
          end else if (k == LAST) begin
            valid[k] <= valid[k-1] && s6_render;
          end else begin
            valid[k] <= valid[k-1];
          end
        end
      end
    end
  end

  assign in_stall = !ready[0];

  // stage 0: products, range checks
  logic [10:0]       fb_col_c;
  logic [9:0]        fb_row_c;
  logic              oor_c;
  logic [19:0]       s0_prod_c;
  logic [17:0]       s0_prod_r;
  logic [10:0]       s0_fb_col;
  logic [9:0]        s0_fb_row;
  logic              s0_oor, s0_op, s0_load_ok;
  logic [ADDR_W-1:0] s0_idx;
  logic [23:0]       s0_pix;

  assign fb_col_c = {1'b0, dst_left} + {1'b0, in_item.dst_col};
  assign fb_row_c = {1'b0, dst_top} + {1'b0, in_item.dst_row};
  assign oor_c = (in_item.dst_col >= dst_width) || (in_item.dst_row >= dst_height)
              || ({2'b0, fb_col_c} >= 13'(FB_STRIDE))
              || ({3'b0, fb_row_c} >= 13'(FB_ROWS));

  always_ff @(posedge clk) begin
    if (move[0]) begin
      s0_prod_c  <= in_item.dst_col * src_width;
      s0_prod_r  <= in_item.dst_row * src_height;
      s0_fb_col  <= fb_col_c;
      s0_fb_row  <= fb_row_c;
      s0_oor     <= oor_c;
      s0_op      <= in_item.op;
      s0_load_ok <= {6'b0, in_item.src_index} < CMP_W'(STORE_DEPTH);
      s0_idx     <= ADDR_W'(in_item.src_index);
      s0_pix     <= {in_item.byte_hi, in_item.byte_mid, in_item.byte_lo};
    end
  end

  // stages 1..DIV_STG: division lanes and side data
  logic [QW-1:0] q_col, q_row;
  logic [31:0]   fb_addr_c;
  side_t         side [1:IDX_STG-1];

  nns_div u_div_col (
    .clk      (clk),
    .adv      (move[DIV_STG:1]),
    .dividend (s0_prod_c),
    .divisor  (dst_width),
    .quotient (q_col)
  );

  nns_div u_div_row (
    .clk      (clk),
    .adv      (move[DIV_STG:1]),
    .dividend ({2'b0, s0_prod_r}),
    .divisor  ({1'b0, dst_height}),
    .quotient (q_row)
  );

  assign fb_addr_c = 32'(s0_fb_row) * 32'(FB_STRIDE) + 32'(s0_fb_col);

  always_ff @(posedge clk) begin
    for (int k = 1; k < IDX_STG; k++) begin
      if (move[k]) begin
        if (k == 1) begin
          side[k] <= '{op: s0_op, oor: s0_oor, fb_address: fb_addr_c[18:0],
                       load_ok: s0_load_ok, idx: s0_idx, pix: s0_pix};
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // stage IDX_STG: source index
  logic [SIDX_W-1:0] sidx_c;
  side_t             s6_next;
  side_t             s6;
  logic [SIDX_W-1:0] s6_sidx;

  assign sidx_c = SIDX_W'(q_row[8:0]) * SIDX_W'(src_width) + SIDX_W'(q_col);

  always_comb begin
    s6_next     = side[IDX_STG-1];
    s6_next.oor = side[IDX_STG-1].oor || ({5'b0, sidx_c} >= CMP_W'(STORE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (move[IDX_STG]) begin
      s6      <= s6_next;
      s6_sidx <= sidx_c;
    end
  end

  assign s6_render = (s6.op == OP_RENDER);

  // last stage: store access and result
  logic              ram_we, ram_re;
  logic [23:0]       ram_rdata;
  logic              s7_oor;
  logic [18:0]       s7_fb_address;

  assign ram_we = move[LAST] && !s6_render && s6.load_ok;
  assign ram_re = move[LAST] && s6_render;

  nns_ram #(
    .WIDTH (24),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s6.idx),
    .wdata (s6.pix),
    .re    (ram_re),
    .raddr (ADDR_W'(s6_sidx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (move[LAST]) begin
      s7_oor        <= s6.oor;
      s7_fb_address <= s6.fb_address;
    end
  end

  assign out_valid               = valid[LAST];
  assign out_item.out_of_range   = s7_oor;
  assign out_item.fb_address     = s7_oor ? '0 : s7_fb_address;
  assign out_item.colour         = s7_oor ? '0 : ram_rdata;

  `ASSERT_IMPLIES(a_flag_zero, clk, rst, out_valid && out_item.out_of_range,
                  out_item.fb_address == '0 && out_item.colour == '0)
  `ASSERT_IMPLIES(a_port_excl, clk, rst, ram_we, !ram_re)
  `ASSERT_NEXT(a_out_source, clk, rst, !valid[LAST-1] && !(valid[LAST] && out_stall),
               !valid[LAST])

endmodule
`default_nettype wire
